@@ src/apc_pkg.sv @@
// Shared types and constants for the APDU response checker.
package apc_pkg;

    localparam int BYTE_W    = 8;
    localparam int CRC_W     = 16;
    localparam int PLEN_W    = 9;
    localparam int CFG_IDX_W = 8;
    localparam int CFG_DAT_W = 16;

    localparam logic [CRC_W-1:0]  CRC_INIT      = 16'hFFFF;
    localparam logic [CRC_W-1:0]  CRC_POLY_RST  = 16'h1021;
    localparam logic [BYTE_W-1:0] SW1_MORE_DATA = 8'h9F;
    localparam logic [BYTE_W-1:0] SW1_OK        = 8'h90;
    localparam logic [BYTE_W-1:0] SW2_OK        = 8'h00;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_CRC_POLY   = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CRC_ENABLE = 8'd1;

    typedef enum logic [2:0] {
        VERDICT_OK         = 3'd0,
        VERDICT_LEN_ERR    = 3'd1,
        VERDICT_GET_RESP   = 3'd2,
        VERDICT_STATUS_ERR = 3'd3,
        VERDICT_CRC_ERR    = 3'd4,
        VERDICT_RETRY_EXH  = 3'd5
    } t_verdict;

    typedef struct packed {
        logic [CRC_W-1:0] crc_poly;
        logic             crc_check_enable;
    } t_cfg;

    typedef struct packed {
        logic [BYTE_W-1:0] get_response_len;
        logic [PLEN_W-1:0] payload_len;
        t_verdict          verdict;
    } t_result;

endpackage

@@ src/apdu_response_checker.sv @@
// Top level of the APDU response checker: handshake, input and result registers, config.
//
// Usage: response bytes enter on the slave stream (tdata = byte, tlast marks the
// final byte of one response). For every response one result item leaves on the
// master stream when its last byte has been processed; other bytes give none.
// The last byte of a response is taken into the input register, which feeds the verdict
// logic; the result register takes that output once it is free to do so.
// Throughput is one byte per cycle while the result is not stalled, set by the
// CRC byte update and delay line.
// The configuration channel is always ready; writes take effect at once. The user
// must make them while no response is in flight; the block does not enforce this.
// Index 0 is the CRC polynomial, index 1 the CRC check enable; other indexes are ignored.
// Reset (synchronous, active low) loads polynomial 0x1021 with checking enabled,
// clears the byte count and pending GET RESPONSE flag and sets the CRC to 0xFFFF.
// When the receiver stalls, the result register holds its item and the input
// register can take one more byte; after that o_s_tready drops until the
// result is taken.
module apdu_response_checker #(
    parameter int MAX_PAYLOAD = 256
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // slave stream
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    input  logic [7:0]                    i_s_tdata,   // [7:0] rsp_byte
    input  logic                          i_s_tlast,
    // master stream
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    output logic [23:0]                   o_m_tdata,   // [2:0] verdict, [11:3] payload_len,
                                                       // [19:12] get_response_len, rest zero
    // configuration write channel
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [apc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [apc_pkg::CFG_DAT_W-1:0] i_cfg_data
);

    logic                       r_in_valid;
    logic [apc_pkg::BYTE_W-1:0] r_in_byte;
    logic                       r_in_last;
    logic                       r_out_valid;
    apc_pkg::t_result           r_out;
    apc_pkg::t_cfg              r_cfg;

    logic                       w_out_free;
    logic                       w_adv;
    logic                       w_res_we;
    apc_pkg::t_result           w_res;

    assign w_out_free  = !r_out_valid || i_m_tready;
    assign o_s_tready  = !r_in_valid || w_out_free;
    assign w_adv       = r_in_valid && w_out_free;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_s_tvalid && o_s_tready) begin
            r_in_valid <= 1'b1;
        end else if (w_adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_tvalid && o_s_tready) begin
            r_in_byte <= i_s_tdata;
            r_in_last <= i_s_tlast;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.crc_poly         <= apc_pkg::CRC_POLY_RST;
            r_cfg.crc_check_enable <= 1'b1;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                apc_pkg::CFG_CRC_POLY:   r_cfg.crc_poly         <= i_cfg_data;
                apc_pkg::CFG_CRC_ENABLE: r_cfg.crc_check_enable <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    apc_frame #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_frame (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_adv),
        .i_byte   (r_in_byte),
        .i_last   (r_in_last),
        .i_cfg    (r_cfg),
        .o_res_we (w_res_we),
        .o_res    (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res_we) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_we) begin
            r_out <= w_res;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {4'b0000, r_out.get_response_len, r_out.payload_len, r_out.verdict};

endmodule

@@ src/apc_crc16.sv @@
// Byte-wide MSB-first CRC-16 update with a programmable polynomial.
module apc_crc16 (
    input  logic [apc_pkg::CRC_W-1:0]  i_crc,
    input  logic [apc_pkg::BYTE_W-1:0] i_byte,
    input  logic [apc_pkg::CRC_W-1:0]  i_poly,
    output logic [apc_pkg::CRC_W-1:0]  o_crc
);

    always_comb begin
        logic [apc_pkg::CRC_W-1:0] c;
        c = i_crc ^ {i_byte, 8'h00};
        for (int k = 0; k < apc_pkg::BYTE_W; k++) begin
            if (c[apc_pkg::CRC_W-1]) begin
                c = {c[apc_pkg::CRC_W-2:0], 1'b0} ^ i_poly;
            end else begin
                c = {c[apc_pkg::CRC_W-2:0], 1'b0};
            end
        end
        o_crc = c;
    end

endmodule

@@ src/apc_frame.sv @@
// Per-response state (count, delay line, CRC, pending flag) and verdict logic.
module apc_frame #(
    parameter int MAX_PAYLOAD = 256
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  logic [apc_pkg::BYTE_W-1:0] i_byte,
    input  logic                       i_last,
    input  apc_pkg::t_cfg              i_cfg,
    output logic                       o_res_we,
    output apc_pkg::t_result           o_res
);

    localparam int CntSat = MAX_PAYLOAD + 3;
    localparam int CW     = $clog2(CntSat + 1);

    logic [CW-1:0]                 r_count;
    logic [apc_pkg::BYTE_W-1:0]    r_tail [4];
    logic [apc_pkg::CRC_W-1:0]     r_crc;
    logic                          r_pending;

    logic [CW-1:0]                 n_count;
    logic [apc_pkg::CRC_W-1:0]     n_crc;
    logic                          n_pending;
    logic [apc_pkg::CRC_W-1:0]     w_crc_fed;
    logic [apc_pkg::CRC_W-1:0]     w_fin;
    logic [CW-1:0]                 w_n_minus2;
    logic [CW+apc_pkg::PLEN_W-1:0] w_plen_ext;

    // The byte leaving the delay line is the oldest one still ahead of the CRC bytes.
    apc_crc16 u_crc (
        .i_crc  (r_crc),
        .i_byte (r_tail[3]),
        .i_poly (i_cfg.crc_poly),
        .o_crc  (w_crc_fed)
    );

    always_comb begin
        n_count    = (r_count < CW'(CntSat)) ? r_count + CW'(1) : r_count;
        n_crc      = (r_count >= CW'(4)) ? w_crc_fed : r_crc;
        w_fin      = ~n_crc;
        w_n_minus2 = n_count - CW'(2);
        w_plen_ext = {{apc_pkg::PLEN_W{1'b0}}, w_n_minus2};

        n_pending              = 1'b0;
        o_res.verdict          = apc_pkg::VERDICT_OK;
        o_res.payload_len      = '0;
        o_res.get_response_len = '0;

        // SW1 is the previous byte, SW2 the current one; the CRC bytes sit just before.
        if (n_count < CW'(2) || n_count > CW'(MAX_PAYLOAD + 2)) begin
            o_res.verdict = apc_pkg::VERDICT_LEN_ERR;
        end else if (n_count == CW'(2) && r_tail[0] == apc_pkg::SW1_MORE_DATA) begin
            if (r_pending) begin
                o_res.verdict = apc_pkg::VERDICT_RETRY_EXH;
            end else begin
                o_res.verdict          = apc_pkg::VERDICT_GET_RESP;
                o_res.get_response_len = i_byte;
                n_pending              = 1'b1;
            end
        end else if (r_tail[0] == apc_pkg::SW1_OK && i_byte == apc_pkg::SW2_OK) begin
            if (i_cfg.crc_check_enable &&
                (n_count < CW'(4) || r_tail[2] != w_fin[15:8] ||
                 r_tail[1] != w_fin[7:0])) begin
                o_res.verdict = apc_pkg::VERDICT_CRC_ERR;
            end else begin
                o_res.payload_len = w_plen_ext[apc_pkg::PLEN_W-1:0];
            end
        end else begin
            o_res.verdict = apc_pkg::VERDICT_STATUS_ERR;
        end
    end

    assign o_res_we = i_en && i_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_crc     <= apc_pkg::CRC_INIT;
            r_pending <= 1'b0;
        end else if (i_en) begin
            if (i_last) begin
                r_count   <= '0;
                r_crc     <= apc_pkg::CRC_INIT;
                r_pending <= n_pending;
            end else begin
                r_count <= n_count;
                r_crc   <= n_crc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_tail[3] <= r_tail[2];
            r_tail[2] <= r_tail[1];
            r_tail[1] <= r_tail[0];
            r_tail[0] <= i_byte;
        end
    end

`ifndef SYNTHESIS
    a_count_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CntSat))
        else $error("byte count above saturation value");

    a_clear_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_we |=> (r_count == '0 && r_crc == apc_pkg::CRC_INIT))
        else $error("frame state not cleared after last byte");

    a_plen_only_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_we && o_res.verdict != apc_pkg::VERDICT_OK) |-> o_res.payload_len == '0)
        else $error("payload length reported on a failing verdict");

    a_retry_needs_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_we && o_res.verdict == apc_pkg::VERDICT_RETRY_EXH) |-> r_pending)
        else $error("retries exhausted without a pending GET RESPONSE");
`endif

endmodule
